@@ sv/fwo_pkg.sv @@
// ----------------------------------------------------------------------------
// fwo_pkg
// Shared types, register codes and the quarter-wave sine table of the faded
// waveform oscillator.
// ----------------------------------------------------------------------------
package fwo_pkg;

    // Quarter-wave sine table geometry (power of two)
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_IDX_W       = SINE_ADDR_W + 1;

    localparam logic [14:0] FULL_SCALE  = 15'd32767;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Taylor series denominators (2n)(2n+1), entry 0 unused
    localparam logic [63:0] TAYLOR_DIV [0:7] = '{
        64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    typedef logic [14:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int          k;
        int          n;
        for (k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x    = (64'(k) * Q30_HALF_PI) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n[2:0]];
                if (n[0])
                    sum = (sum >= term) ? sum - term : 64'd0;
                else
                    sum = sum + term;
            end
            v = (sum * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
            if (v > 64'(FULL_SCALE))
                v = 64'(FULL_SCALE);
            rom[k] = v[14:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_WAVEFORM_KIND = 2'd0;
    localparam logic [1:0] REG_CHUNK_LENGTH  = 2'd1;
    localparam logic [1:0] REG_AMPLITUDE     = 2'd2;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SILENCE  = 2'd3
    } wave_kind_t;

    localparam logic [15:0] CHUNK_LENGTH_RST = 16'd32000;
    localparam logic [14:0] AMPLITUDE_RST    = 15'd21845;

    // len/10 as (len * 52429) >> 19, exact for 16-bit len
    localparam logic [15:0] RECIP_TEN       = 16'd52429;
    localparam int          RECIP_TEN_SHIFT = 19;
    localparam int          LEN10_W         = 13;

    // Fade divider: 16 quotient bits, two per cycle
    localparam int QUOT_W    = 16;
    localparam int DIV_CNT_W = 3;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W / 2 - 1);

    // Queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] phase;
        logic [15:0] index;
        logic [15:0] tail;
        logic        in_tail;
        logic        last;
    } fwo_item_t;

    typedef struct packed {
        wave_kind_t  kind;
        logic [15:0] chunk_length;
        logic [14:0] amplitude;
    } fwo_cfg_t;

endpackage

@@ sv/fwo_front.sv @@
// ----------------------------------------------------------------------------
// fwo_front
// Accepts sample requests, owns the phase accumulator and sample index, and
// tags each beat with its phase, index, distance to chunk end and last flag.
// ----------------------------------------------------------------------------
module fwo_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       phase_step,
    input  logic              first,
    input  logic [15:0]       chunk_length,
    input  logic              full,
    output logic              push,
    output fwo_pkg::fwo_item_t item
);

    logic [31:0] phase_acc_reg;
    logic [31:0] phase_acc_next;
    logic [15:0] sample_index_reg;
    logic [15:0] sample_index_next;
    logic [31:0] cur_phase;
    logic [15:0] cur_index;
    logic [15:0] len;

    assign in_stall = full;
    assign push     = in_valid && !full;

    always_comb
    begin
        cur_phase = first ? 32'd0 : phase_acc_reg;
        cur_index = first ? 16'd0 : sample_index_reg;
        len       = (chunk_length == 16'd0) ? 16'd1 : chunk_length;

        item.phase   = cur_phase;
        item.index   = cur_index;
        item.tail    = len - 16'd1 - cur_index;
        item.in_tail = cur_index < len;
        item.last    = cur_index == (len - 16'd1);

        phase_acc_next    = cur_phase + phase_step;
        sample_index_next = cur_index + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
        end
        else if (push)
        begin
            phase_acc_reg    <= phase_acc_next;
            sample_index_reg <= sample_index_next;
        end
    end

endmodule

@@ sv/fwo_queue.sv @@
// ----------------------------------------------------------------------------
// fwo_queue
// Short FIFO of tagged beats between the front and the back.
// ----------------------------------------------------------------------------
module fwo_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fwo_pkg::fwo_item_t push_item,
    input  logic               pop,
    output fwo_pkg::fwo_item_t head,
    output logic               full,
    output logic               empty
);

    fwo_pkg::fwo_item_t              mem_reg [fwo_pkg::QUEUE_DEPTH];
    logic [fwo_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [fwo_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [fwo_pkg::QCNT_W-1:0]      count_reg;
    logic [fwo_pkg::QCNT_W-1:0]      count_next;

    assign full  = count_reg == fwo_pkg::QCNT_W'(fwo_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ sv/fwo_back.sv @@
// ----------------------------------------------------------------------------
// fwo_back
// Sequencer that turns one tagged beat into a sample: wave lookup, amplitude
// scale, fade in and fade out through a shared multiplier and a radix-4
// divider, then the output register.
// ----------------------------------------------------------------------------
module fwo_back #(
    parameter int MAX_FADE = 50
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fwo_pkg::fwo_cfg_t  cfg,
    input  logic               empty,
    input  fwo_pkg::fwo_item_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample,
    output logic               last
);

    localparam int FW = $clog2(MAX_FADE + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WAVE  = 6'b000010,
        S_SCALE = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    fwo_pkg::fwo_item_t item_reg;
    logic [FW-1:0]      fade_reg;
    logic [14:0]        wave_mag_reg;
    logic [14:0]        wave_mag_next;
    logic               neg_reg;
    logic               neg_next;
    logic [14:0]        mag_reg;
    logic               fin_reg;
    logic               fout_reg;
    logic [FW-1:0]      rem_reg;
    logic [fwo_pkg::QUOT_W-1:0]    dq_reg;
    logic [fwo_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic               out_valid_reg;
    logic signed [15:0] sample_reg;
    logic               last_reg;

    // fade length from chunk length
    logic [31:0]                 len_prod;
    logic [fwo_pkg::LEN10_W-1:0] len10;
    logic [FW-1:0]               fade_next;

    // wave lookup
    logic [fwo_pkg::SINE_ADDR_W-1:0] sine_pos;
    logic [fwo_pkg::SINE_IDX_W-1:0]  sine_idx;
    logic [31:0]                     tri_dist;
    logic [47:0]                     tri_acc;
    logic [15:0]                     tri_drop;

    // shared multiplier
    logic [14:0] mul_a;
    logic [14:0] mul_b;
    logic [29:0] mul_p;
    logic [29:0] scale_sum;

    // divider step
    logic [FW:0]                  r1;
    logic [FW:0]                  r2;
    logic                         ge1;
    logic                         ge2;
    logic [FW-1:0]                r1s;
    logic [FW-1:0]                r2s;
    logic [fwo_pkg::QUOT_W-1:0]   dq1;
    logic [fwo_pkg::QUOT_W-1:0]   dq2;

    logic        out_free;
    logic [15:0] mag_ext;
    logic [15:0] sample_next;

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == S_IDLE) && !empty;

    always_comb
    begin
        len_prod  = 32'(cfg.chunk_length) * 32'(fwo_pkg::RECIP_TEN);
        len10     = len_prod[fwo_pkg::RECIP_TEN_SHIFT +: fwo_pkg::LEN10_W];
        fade_next = (len10 > fwo_pkg::LEN10_W'(MAX_FADE)) ? FW'(MAX_FADE)
                                                          : len10[FW-1:0];
    end

    always_comb
    begin
        sine_pos = item_reg.phase[29 -: fwo_pkg::SINE_ADDR_W];
        sine_idx = item_reg.phase[30]
                 ? fwo_pkg::SINE_IDX_W'(fwo_pkg::SINE_TABLE_DEPTH) - {1'b0, sine_pos}
                 : {1'b0, sine_pos};

        tri_dist = item_reg.phase[31] ? {1'b0, item_reg.phase[30:0]}
                                      : 32'h8000_0000 - {1'b0, item_reg.phase[30:0]};
        tri_acc  = {tri_dist, 16'd0} - {15'd0, tri_dist, 1'b0} + 48'h0000_4000_0000;
        tri_drop = tri_acc[46:31];

        case (cfg.kind)
            fwo_pkg::WAVE_SINE:
            begin
                wave_mag_next = fwo_pkg::SINE_ROM[sine_idx];
                neg_next      = item_reg.phase[31];
            end
            fwo_pkg::WAVE_TRIANGLE:
            begin
                neg_next      = tri_drop > 16'(fwo_pkg::FULL_SCALE);
                wave_mag_next = neg_next ? 15'(tri_drop - 16'(fwo_pkg::FULL_SCALE))
                                         : 15'(16'(fwo_pkg::FULL_SCALE) - tri_drop);
            end
            fwo_pkg::WAVE_SQUARE:
            begin
                wave_mag_next = fwo_pkg::FULL_SCALE;
                neg_next      = item_reg.phase[31];
            end
            default:
            begin
                wave_mag_next = '0;
                neg_next      = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_SCALE)
        begin
            mul_a = wave_mag_reg;
            mul_b = cfg.amplitude;
        end
        else
        begin
            mul_a = mag_reg;
            mul_b = fin_reg ? 15'(item_reg.index[FW-1:0]) : 15'(item_reg.tail[FW-1:0]);
        end
        mul_p     = 30'(mul_a) * 30'(mul_b);
        scale_sum = mul_p + 30'd16384;
    end

    // two restoring steps per cycle
    always_comb
    begin
        r1  = {rem_reg, dq_reg[fwo_pkg::QUOT_W-1]};
        ge1 = r1 >= {1'b0, fade_reg};
        r1s = ge1 ? FW'(r1 - {1'b0, fade_reg}) : r1[FW-1:0];
        dq1 = {dq_reg[fwo_pkg::QUOT_W-2:0], ge1};
        r2  = {r1s, dq1[fwo_pkg::QUOT_W-1]};
        ge2 = r2 >= {1'b0, fade_reg};
        r2s = ge2 ? FW'(r2 - {1'b0, fade_reg}) : r2[FW-1:0];
        dq2 = {dq1[fwo_pkg::QUOT_W-2:0], ge2};
    end

    always_comb
    begin
        mag_ext     = {1'b0, mag_reg};
        sample_next = neg_reg ? 16'd0 - mag_ext : mag_ext;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (!empty)
                    state_next = S_WAVE;
            S_WAVE:
                state_next = S_SCALE;
            S_SCALE:
                if ((item_reg.index < 16'(fade_reg)) ||
                    (item_reg.in_tail && (item_reg.tail < 16'(fade_reg))))
                    state_next = S_MUL;
                else
                    state_next = S_DONE;
            S_MUL:
                state_next = S_DIV;
            S_DIV:
                if (div_cnt_reg == fwo_pkg::DIV_LAST)
                    state_next = (fin_reg && fout_reg) ? S_MUL : S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        fade_reg <= fade_next;
        if (pop)
            item_reg <= head;
        if (state_reg == S_WAVE)
        begin
            wave_mag_reg <= wave_mag_next;
            neg_reg      <= neg_next;
        end
        if (state_reg == S_SCALE)
        begin
            mag_reg  <= scale_sum[29:15];
            fin_reg  <= item_reg.index < 16'(fade_reg);
            fout_reg <= item_reg.in_tail && (item_reg.tail < 16'(fade_reg));
        end
        if (state_reg == S_MUL)
        begin
            // quotient fits 16 bits, so the top bits start below the divisor
            rem_reg     <= mul_p[fwo_pkg::QUOT_W +: FW];
            dq_reg      <= mul_p[fwo_pkg::QUOT_W-1:0];
            div_cnt_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            rem_reg     <= r2s;
            dq_reg      <= dq2;
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_cnt_reg == fwo_pkg::DIV_LAST)
            begin
                mag_reg <= dq2[14:0];
                fin_reg <= 1'b0;
            end
        end
        if (state_reg == S_DONE && out_free)
        begin
            sample_reg <= sample_next;
            last_reg   <= item_reg.last;
        end
    end

endmodule

@@ sv/faded_waveform_oscillator_top.sv @@
// ----------------------------------------------------------------------------
// faded_waveform_oscillator_top
// Oscillator with sine, triangle and square waves, amplitude scale and
// linear fade at both ends of a note chunk, with an APB register port.
// ----------------------------------------------------------------------------
//   channel   signals                              beat on
//   -------   ----------------------------------   -------------------------
//   in        in_valid in_stall phase_step first   in_valid && !in_stall
//   out       out_valid out_stall sample last      out_valid && !out_stall
//   apb       psel penable pwrite paddr pwdata     psel && penable && pwrite
//
// A sample passes through the back sequencer's states in order: pop, wave, scale, output.
// Each fade that applies adds a multiply step and a pass through the
// two-bit-per-cycle divider, and a beat in both fades makes both passes.
// A two-entry queue lets the front take beats while the back is busy.
// Reset clears the phase, the sample index, the queue and the output valid.
// A stalled output holds; the back keeps working until it must write it.
// ----------------------------------------------------------------------------
module faded_waveform_oscillator_top #(
    parameter int MAX_FADE = 50
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [31:0]                        phase_step,
    input  logic                               first,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [15:0]                 sample,
    output logic                               last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fwo_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fwo_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fwo_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    fwo_pkg::wave_kind_t kind_reg;
    logic [15:0]         chunk_length_reg;
    logic [14:0]         amplitude_reg;
    logic                wr_en;
    logic [1:0]          reg_sel;

    fwo_pkg::fwo_cfg_t   cfg;
    fwo_pkg::fwo_item_t  front_item;
    fwo_pkg::fwo_item_t  queue_head;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[fwo_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg         <= fwo_pkg::WAVE_SINE;
            chunk_length_reg <= fwo_pkg::CHUNK_LENGTH_RST;
            amplitude_reg    <= fwo_pkg::AMPLITUDE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                fwo_pkg::REG_WAVEFORM_KIND: kind_reg <= fwo_pkg::wave_kind_t'(pwdata[1:0]);
                fwo_pkg::REG_CHUNK_LENGTH:  chunk_length_reg <= pwdata[15:0];
                fwo_pkg::REG_AMPLITUDE:     amplitude_reg <= pwdata[14:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            fwo_pkg::REG_WAVEFORM_KIND: prdata = {30'd0, kind_reg};
            fwo_pkg::REG_CHUNK_LENGTH:  prdata = {16'd0, chunk_length_reg};
            fwo_pkg::REG_AMPLITUDE:     prdata = {17'd0, amplitude_reg};
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.kind         = kind_reg;
        cfg.chunk_length = chunk_length_reg;
        cfg.amplitude    = amplitude_reg;
    end

    fwo_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .phase_step   (phase_step),
        .first        (first),
        .chunk_length (chunk_length_reg),
        .full         (full),
        .push         (push),
        .item         (front_item)
    );

    fwo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (queue_head),
        .full      (full),
        .empty     (empty)
    );

    fwo_back #(
        .MAX_FADE (MAX_FADE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (empty),
        .head      (queue_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .last      (last)
    );

endmodule

@@ sv/fwo_checker.sv @@
// ----------------------------------------------------------------------------
// fwo_checker
// Port-level checks on the oscillator: output hold under stall, sample range
// and amplitude register read-back.
// ----------------------------------------------------------------------------
module fwo_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [15:0]             sample,
    input logic                           last,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [fwo_pkg::APB_ADDR_W-1:0] paddr,
    input logic [fwo_pkg::APB_DATA_W-1:0] pwdata,
    input logic [fwo_pkg::APB_DATA_W-1:0] prdata
);

    localparam logic [fwo_pkg::APB_ADDR_W-1:0] AMP_ADDR = {fwo_pkg::REG_AMPLITUDE, 2'b00};

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped under stall");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample) && $stable(last))
        else $error("stalled output beat changed");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != 16'sh8000)
        else $error("sample outside symmetric Q1.15 range");

    a_amp_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr == AMP_ADDR) ##1
        (psel && !pwrite && paddr == AMP_ADDR)
        |-> prdata == 32'($past(pwdata[14:0])))
        else $error("amplitude read-back mismatch");

endmodule

bind faded_waveform_oscillator_top fwo_checker u_fwo_checker (.*);

@@ verif/faded_waveform_oscillator_top_tb.sv @@
// ----------------------------------------------------------------------------
// faded_waveform_oscillator_top_tb
// Self-checking bench for the faded waveform oscillator. A short table of
// directed beats covers reset values, register masking, every wave kind, zero
// and unit chunk lengths and restarts. Random phases of note chunks follow,
// with random register settings and random gaps and stalls on both channels.
// Each output beat is checked against an in-bench model, or the table's own sample.
// ----------------------------------------------------------------------------
module faded_waveform_oscillator_top_tb;

    localparam int              FADE_CAP     = 50;
    localparam int              QTR_DEPTH    = 256;
    localparam int              PEAK         = 32767;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam int              SETTLE       = 30;
    localparam int              RANDOM_BEATS = 1730;
    localparam logic [1:0]      REG_UNUSED   = 2'd3;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } note_sample_t;

    typedef struct packed {
        logic                wr;
        fwo_pkg::wave_kind_t kind;
        logic [31:0]         len_word;
        logic [31:0]         amp_word;
        logic [31:0]         step;
        logic                first;
        logic                typed;
        logic [15:0]         want_sample;
        logic                want_last;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // reset settings: fade in silences index 0
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h0000_0000, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h4000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        // zero length acts as one, high register bits dropped
        '{1'b1, fwo_pkg::WAVE_SQUARE,   32'hFFFF_0000, 32'hFFFF_FFFF,
          32'h8000_0000, 1'b1, 1'b0, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h0000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        // zero amplitude
        '{1'b1, fwo_pkg::WAVE_TRIANGLE, 32'd1,         32'd0,
          32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0, 1'b1},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'hFFFF_FFFF, 1'b0, 1'b1, 16'd0, 1'b0},
        // silence
        '{1'b1, fwo_pkg::WAVE_SILENCE,  32'd20,        32'd32767,
          32'h1234_5678, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'hEDCB_A987, 1'b0, 1'b1, 16'd0, 1'b0},
        // sine quadrants, no fade, then one past the chunk end
        '{1'b1, fwo_pkg::WAVE_SINE,     32'd5,         32'h0000_7FFF,
          32'h4000_0000, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h4000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h4000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h4000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h4000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h0000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        // longest chunk, triangle
        '{1'b1, fwo_pkg::WAVE_TRIANGLE, 32'hFFFF_FFFF, 32'h0000_7FFF,
          32'h8000_0000, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h0000_0001, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h8000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        // smallest nonzero amplitude, square
        '{1'b1, fwo_pkg::WAVE_SQUARE,   32'd65535,     32'd1,
          32'h7FFF_FFFF, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0, 1'b0},
        // restart in mid chunk
        '{1'b0, fwo_pkg::WAVE_SINE,     32'd0,         32'd0,
          32'h0000_0000, 1'b1, 1'b1, 16'd0, 1'b0}
    };

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_stall;
    logic [31:0]                           phase_step;
    logic                                  first;
    logic                                  out_valid;
    logic                                  out_stall;
    logic signed [15:0]                    sample;
    logic                                  last;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [fwo_pkg::APB_ADDR_W-1:0]        paddr;
    logic [fwo_pkg::APB_DATA_W-1:0]        pwdata;
    logic [fwo_pkg::APB_DATA_W-1:0]        prdata;
    logic                                  pready;

    // oscillator model state and register mirror
    int                  quarter_wave [0:QTR_DEPTH];
    fwo_pkg::wave_kind_t cur_kind;
    logic [15:0]         cur_len;
    logic [14:0]         cur_amp;
    logic [31:0]         osc_phase;
    logic [15:0]         osc_index;

    note_sample_t pending_samples [$];
    int           errors;
    int           stall_left;
    bit           steady;

    faded_waveform_oscillator_top #(
        .MAX_FADE (FADE_CAP)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .phase_step (phase_step),
        .first      (first),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // quarter-wave table, Q30 Taylor series
    initial
    begin
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned val;
        for (int k = 0; k <= QTR_DEPTH; k++)
        begin
            ang    = (64'(k) * HALF_PI_Q30) / QTR_DEPTH;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = ang;
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * ang_sq) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
                // odd terms subtract, floored at zero
                if (n % 2 == 1)
                    acc = (acc >= term) ? acc - term : 64'd0;
                else
                    acc = acc + term;
            end
            val = (acc * PEAK + 64'd536870912) >> 30;
            quarter_wave[k] = (val > PEAK) ? PEAK : int'(val);
        end
    end

    function automatic int wave_at(input logic [31:0] p);
        longint unsigned pos;
        longint unsigned half_dist;
        longint unsigned drop;
        int              v;
        case (cur_kind)
            fwo_pkg::WAVE_SINE:
            begin
                pos = (64'(p[29:0]) * QTR_DEPTH) >> 30;
                // mirror in odd quadrants, negate in the second half cycle
                v = quarter_wave[p[30] ? QTR_DEPTH - pos : pos];
                return p[31] ? -v : v;
            end
            fwo_pkg::WAVE_TRIANGLE:
            begin
                half_dist = p[31] ? 64'(p - 32'h8000_0000) : 64'(32'h8000_0000 - p);
                drop      = (half_dist * 64'd65534 + 64'd1073741824) >> 31;
                return PEAK - int'(drop);
            end
            fwo_pkg::WAVE_SQUARE:
                return p[31] ? -PEAK : PEAK;
            default:
                return 0;
        endcase
    endfunction

    function automatic note_sample_t predict_sample(input logic [31:0] step, input logic start);
        note_sample_t    res;
        int unsigned     len;
        int unsigned     fade;
        int unsigned     i;
        int              w;
        longint unsigned mag;
        if (start)
        begin
            osc_phase = '0;
            osc_index = '0;
        end
        len  = (cur_len == 16'd0) ? 1 : cur_len;
        fade = (len / 10 > FADE_CAP) ? FADE_CAP : len / 10;
        i    = osc_index;
        w    = wave_at(osc_phase);
        mag  = (w < 0) ? -w : w;
        mag  = (mag * cur_amp + 64'd16384) >> 15;
        // fade in first, then fade out, each truncating
        if (i < fade)
            mag = mag * i / fade;
        if (i < len && len - 1 - i < fade)
            mag = mag * (len - 1 - i) / fade;
        if (mag > PEAK)
            mag = PEAK;
        res.sample = (w < 0) ? -16'(mag) : 16'(mag);
        res.last   = (i == len - 1);
        osc_phase  = osc_phase + step;
        osc_index  = osc_index + 16'd1;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h0000_0000;
                1:       return 32'h0000_0001;
                2:       return 32'h4000_0000;
                3:       return 32'h8000_0000;
                4:       return 32'h7FFF_FFFF;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 5)
            return $urandom();
        // audio range: well below half a cycle per sample
        if (r < 9)
            return $urandom_range(0, 32'h0100_0000);
        return $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
    endfunction

    task automatic flag_error(input string what);
        errors++;
        if (errors <= 10)
            $display("%s", what);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            fwo_pkg::REG_WAVEFORM_KIND: cur_kind = fwo_pkg::wave_kind_t'(word[1:0]);
            fwo_pkg::REG_CHUNK_LENGTH:  cur_len  = word[15:0];
            fwo_pkg::REG_AMPLITUDE:     cur_amp  = word[14:0];
            default:                    ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(input logic [31:0] step, input logic start, input logic typed,
                             input logic [15:0] t_sample, input logic t_last);
        note_sample_t want;
        int           gap;
        in_valid   <= 1'b1;
        phase_step <= step;
        first      <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = predict_sample(step, start);
        if (typed)
        begin
            want.sample = t_sample;
            want.last   = t_last;
        end
        pending_samples.insert(pending_samples.size(), want);
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // output stall: one free cycle, then a random stall burst
    initial
    begin
        out_stall  <= 1'b0;
        stall_left  = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        note_sample_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
                flag_error($sformatf("unexpected output beat: sample %0d last %0b",
                                     sample, last));
            else
            begin
                want = pending_samples[0];
                pending_samples.delete(0);
                if (sample !== want.sample)
                    flag_error($sformatf("sample: expected %0d, got %0d",
                                         want.sample, sample));
                if (last !== want.last)
                    flag_error($sformatf("last: expected %0b, got %0b", want.last, last));
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("faded_waveform_oscillator_top: mismatch");
        $finish;
    end

    initial
    begin
        dir_row_t            row;
        fwo_pkg::wave_kind_t kind;
        logic [15:0]         len;
        logic [14:0]         amp;
        logic [31:0]         junk;
        logic [31:0]         base;
        logic [31:0]         step;
        logic                start;
        int                  random_beats;
        int                  chunks;
        int                  span;
        int                  n;
        int                  r;

        errors     = 0;
        steady     = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        phase_step <= '0;
        first      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        // register values after reset
        cur_kind  = fwo_pkg::WAVE_SINE;
        cur_len   = 16'd32000;
        cur_amp   = 15'd21845;
        osc_phase = '0;
        osc_index = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
        begin
            row = DIRECTED[k];
            if (row.wr)
            begin
                wait_drained();
                reg_write(fwo_pkg::REG_WAVEFORM_KIND, 32'hFFFF_FFFC | 32'(row.kind));
                reg_write(fwo_pkg::REG_CHUNK_LENGTH, row.len_word);
                reg_write(fwo_pkg::REG_AMPLITUDE, row.amp_word);
                // must not alias any real register
                reg_write(REG_UNUSED, 32'hFFFF_FFFF);
            end
            send_beat(row.step, row.first, row.typed, row.want_sample, row.want_last);
        end

        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            wait_drained();
            steady = ($urandom_range(0, 4) == 0);
            kind   = fwo_pkg::wave_kind_t'($urandom_range(0, 3));
            case ($urandom_range(0, 19))
                0:          len = 16'd0;
                1:          len = 16'd1;
                2:          len = 16'hFFFF;
                3, 4:       len = 16'($urandom_range(2, 20));
                15, 16, 17,
                18, 19:     len = 16'($urandom_range(121, 700));
                default:    len = 16'($urandom_range(21, 120));
            endcase
            case ($urandom_range(0, 9))
                0:       amp = 15'd0;
                1:       amp = 15'h7FFF;
                default: amp = 15'($urandom_range(0, 32767));
            endcase
            junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
            reg_write(fwo_pkg::REG_WAVEFORM_KIND, (junk & ~32'h3) | 32'(kind));
            reg_write(fwo_pkg::REG_CHUNK_LENGTH, (junk & ~32'hFFFF) | 32'(len));
            reg_write(fwo_pkg::REG_AMPLITUDE, (junk & ~32'h7FFF) | 32'(amp));
            if ($urandom_range(0, 3) == 0)
                reg_write(REG_UNUSED, $urandom());

            chunks = $urandom_range(1, 4);
            repeat (chunks)
            begin
                span = (len == 16'd0) ? 1 : int'(len);
                r    = $urandom_range(0, 9);
                // mostly whole chunks; some cut short, some running past the end
                if (r < 7)
                    n = span;
                else if (r < 9)
                    n = $urandom_range(1, span);
                else
                    n = span + $urandom_range(1, 30);
                if (n > 800)
                    n = $urandom_range(60, 200);
                base = pick_step();
                for (int j = 0; j < n; j++)
                begin
                    step  = ($urandom_range(0, 9) == 0) ? $urandom() : base;
                    start = (j == 0);
                    if ($urandom_range(0, 29) == 0)
                        start = $urandom_range(0, 1);
                    send_beat(step, start, 1'b0, 16'd0, 1'b0);
                end
                random_beats += n;
            end
        end

        wait_drained();
        if (errors == 0 && pending_samples.size() == 0)
            $display("faded_waveform_oscillator_top: match");
        else
            $display("faded_waveform_oscillator_top: mismatch");
        $finish;
    end

endmodule
